// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEVER(label, cond)
`endif

`endif

// File: sv/adpcm4_pkg.sv
// ---------------------------------------------------------------------------
// adpcm4_pkg
// Types, constants and lookup tables for the 4-bit ADPCM decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adpcm4_pkg;

  localparam int unsigned StepCount = 49;
  localparam logic [5:0]  MaxIdx    = 6'(StepCount - 1);

  // Signal limits, 14-bit signed working width
  localparam logic signed [13:0] SigMax = 14'sd2047;
  localparam logic signed [13:0] SigMin = -14'sd2048;

  // Output limits, 21-bit signed working width
  localparam logic signed [20:0] OutMax = 21'sd32767;
  localparam logic signed [20:0] OutMin = -21'sd32768;

  typedef enum logic [1:0] {
    ActDecode  = 2'd0,
    ActSave    = 2'd1,
    ActRestore = 2'd2
  } action_e;

  // Input item, action in the low bits
  typedef struct packed {
    logic [3:0] code_nibble;
    logic [1:0] action;
  } in_item_t;

  // Decoded sample on its way to the gain stage
  typedef struct packed {
    logic               valid;
    logic signed [11:0] signal;
  } mid_t;

  // Step size table, floor(16 * 1.1^i)
  function automatic logic [10:0] step_size(input logic [5:0] idx);
    logic [10:0] st;
    unique case (idx)
      6'd0:  st = 11'd16;   6'd1:  st = 11'd17;   6'd2:  st = 11'd19;
      6'd3:  st = 11'd21;   6'd4:  st = 11'd23;   6'd5:  st = 11'd25;
      6'd6:  st = 11'd28;   6'd7:  st = 11'd31;   6'd8:  st = 11'd34;
      6'd9:  st = 11'd37;   6'd10: st = 11'd41;   6'd11: st = 11'd45;
      6'd12: st = 11'd50;   6'd13: st = 11'd55;   6'd14: st = 11'd60;
      6'd15: st = 11'd66;   6'd16: st = 11'd73;   6'd17: st = 11'd80;
      6'd18: st = 11'd88;   6'd19: st = 11'd97;   6'd20: st = 11'd107;
      6'd21: st = 11'd118;  6'd22: st = 11'd130;  6'd23: st = 11'd143;
      6'd24: st = 11'd157;  6'd25: st = 11'd173;  6'd26: st = 11'd190;
      6'd27: st = 11'd209;  6'd28: st = 11'd230;  6'd29: st = 11'd253;
      6'd30: st = 11'd279;  6'd31: st = 11'd307;  6'd32: st = 11'd337;
      6'd33: st = 11'd371;  6'd34: st = 11'd408;  6'd35: st = 11'd449;
      6'd36: st = 11'd494;  6'd37: st = 11'd544;  6'd38: st = 11'd598;
      6'd39: st = 11'd658;  6'd40: st = 11'd724;  6'd41: st = 11'd796;
      6'd42: st = 11'd876;  6'd43: st = 11'd963;  6'd44: st = 11'd1060;
      6'd45: st = 11'd1166; 6'd46: st = 11'd1282; 6'd47: st = 11'd1411;
      default: st = 11'd1552;
    endcase
    return st;
  endfunction

  // Step index adjustment by code magnitude
  function automatic logic signed [6:0] index_move(input logic [2:0] mag);
    logic signed [6:0] mv;
    unique case (mag)
      3'd4:    mv = 7'sd2;
      3'd5:    mv = 7'sd4;
      3'd6:    mv = 7'sd6;
      3'd7:    mv = 7'sd8;
      default: mv = -7'sd1;
    endcase
    return mv;
  endfunction

endpackage

`default_nettype wire

// File: sv/adpcm_4bit_decoder.sv
// ---------------------------------------------------------------------------
// adpcm_4bit_decoder
// 4-bit ADPCM decoder to 12-bit signal with loop save/restore and Q8.8 gain.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  s_axis  | in        | tdata[1:0] action, tdata[5:2] code_nibble
//  m_axis  | out       | tdata[15:0] sample (signed)
//  cfg     | in        | cfg_wdata_i = gain_q8_8, written when cfg_we_i
//
//  One item per cycle sustained while m_axis_tready stays high; a decode
//  result passes the input register, then the decode state and mid stage,
//  then the gain output register before it is valid on m_axis. The
//  signal/step recurrence is combinational back into its own registers.
//  Save, restore and unused actions give no result.
//  Reset clears all loop state and sets the gain to 1.0; no clearing pass.
//  Output stalls reach s_axis_tready through a combinational ready chain;
//  each stage keeps taking data while it is empty or its successor drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adpcm_4bit_decoder
  import adpcm4_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] action, [5:2] code_nibble
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  in_item_t in_item;
  mid_t     mid;
  logic     mid_ready;

  assign in_item.action      = s_axis_tdata[1:0];
  assign in_item.code_nibble = s_axis_tdata[5:2];

  adpcm4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .mid_o       (mid),
    .mid_ready_i (mid_ready)
  );

  adpcm4_gain u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mid_i        (mid),
    .mid_ready_o  (mid_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: sv/adpcm4_core.sv
// ---------------------------------------------------------------------------
// adpcm4_core
// Input register and decode recurrence: signal, step index, loop save/restore.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adpcm4_core
  import adpcm4_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output mid_t          mid_o,
  input  wire logic     mid_ready_i
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     mid_free, in_go;

  logic signed [11:0] signal_q, signal_d;
  logic [5:0]         step_idx_q, step_idx_d;
  logic signed [11:0] loop_signal_q, loop_signal_d;
  logic [5:0]         loop_idx_q, loop_idx_d;
  logic               loop_saved_q, loop_saved_d;
  logic               mid_valid_q, mid_valid_d;
  logic signed [11:0] mid_signal_q, mid_signal_d;

  logic [10:0]        st;
  logic [11:0]        diff_mag;
  logic signed [13:0] sig_sum, sig_clamped;
  logic signed [6:0]  idx_sum;
  logic [5:0]         idx_clamped;
  logic               do_save, do_restore;

  // Handshake: item leaves the input register when the mid stage frees up
  assign mid_free   = !mid_valid_q || mid_ready_i;
  assign in_go      = in_valid_q && mid_free;
  assign in_ready_o = !in_valid_q || mid_free;
  assign do_save    = in_go && (action_e'(in_item_q.action) == ActSave);
  assign do_restore = in_go && (action_e'(in_item_q.action) == ActRestore);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Difference from step size and code magnitude
  always_comb begin
    st       = step_size(step_idx_q);
    diff_mag = {4'd0, st[10:3]};
    if (in_item_q.code_nibble[2]) diff_mag = diff_mag + {1'b0, st};
    if (in_item_q.code_nibble[1]) diff_mag = diff_mag + {2'd0, st[10:1]};
    if (in_item_q.code_nibble[0]) diff_mag = diff_mag + {3'd0, st[10:2]};
  end

  // Signal update with saturation
  always_comb begin
    if (in_item_q.code_nibble[3]) begin
      sig_sum = 14'(signal_q) - $signed({2'b00, diff_mag});
    end else begin
      sig_sum = 14'(signal_q) + $signed({2'b00, diff_mag});
    end
    if (sig_sum > SigMax) begin
      sig_clamped = SigMax;
    end else if (sig_sum < SigMin) begin
      sig_clamped = SigMin;
    end else begin
      sig_clamped = sig_sum;
    end
  end

  // Step index update with clamp
  always_comb begin
    idx_sum = $signed({1'b0, step_idx_q}) + index_move(in_item_q.code_nibble[2:0]);
    if (idx_sum < 7'sd0) begin
      idx_clamped = '0;
    end else if (idx_sum > $signed({1'b0, MaxIdx})) begin
      idx_clamped = MaxIdx;
    end else begin
      idx_clamped = idx_sum[5:0];
    end
  end

  // Next state by action
  always_comb begin
    signal_d      = signal_q;
    step_idx_d    = step_idx_q;
    loop_signal_d = loop_signal_q;
    loop_idx_d    = loop_idx_q;
    loop_saved_d  = loop_saved_q;
    mid_signal_d  = mid_signal_q;
    mid_valid_d   = mid_ready_i ? 1'b0 : mid_valid_q;
    if (in_go) begin
      unique case (action_e'(in_item_q.action))
        ActDecode: begin
          signal_d     = sig_clamped[11:0];
          step_idx_d   = idx_clamped;
          mid_signal_d = sig_clamped[11:0];
          mid_valid_d  = 1'b1;
        end
        ActSave: begin
          if (!loop_saved_q) begin
            loop_signal_d = signal_q;
            loop_idx_d    = step_idx_q;
            loop_saved_d  = 1'b1;
          end
        end
        ActRestore: begin
          signal_d   = loop_signal_q;
          step_idx_d = loop_idx_q;
        end
        default: ;
      endcase
    end
  end

  // Loop state and mid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signal_q      <= '0;
      step_idx_q    <= '0;
      loop_signal_q <= '0;
      loop_idx_q    <= '0;
      loop_saved_q  <= 1'b0;
      mid_valid_q   <= 1'b0;
    end else begin
      signal_q      <= signal_d;
      step_idx_q    <= step_idx_d;
      loop_signal_q <= loop_signal_d;
      loop_idx_q    <= loop_idx_d;
      loop_saved_q  <= loop_saved_d;
      mid_valid_q   <= mid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_signal_q <= mid_signal_d;
  end

  assign mid_o.valid  = mid_valid_q;
  assign mid_o.signal = mid_signal_q;

  // Checks
  `ASSERT_ALWAYS(a_idx_range, step_idx_q <= MaxIdx)
  `ASSERT_NEVER(a_saved_sticky, $fell(loop_saved_q))
  `ASSERT_ALWAYS(a_restore_sig, do_restore |=> signal_q == $past(loop_signal_q))
  `ASSERT_ALWAYS(a_restore_idx, do_restore |=> step_idx_q == $past(loop_idx_q))
  `ASSERT_ALWAYS(a_save_once, do_save && loop_saved_q |=> $stable({loop_signal_q, loop_idx_q}))

endmodule

`default_nettype wire

// File: sv/adpcm4_gain.sv
// ---------------------------------------------------------------------------
// adpcm4_gain
// Gain register, Q8.8 multiply with truncation toward zero, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adpcm4_gain
  import adpcm4_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire mid_t        mid_i,
  output logic             mid_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      out_sample_o
);

  logic [15:0]        gain_q;
  logic               out_valid_q;
  logic signed [15:0] out_sample_q, out_sample_d;
  logic signed [16:0] gain_s;
  logic signed [28:0] prod, prod_biased;
  logic signed [20:0] quot;
  logic               load;

  assign mid_ready_o = !out_valid_q || out_ready_i;
  assign load        = mid_i.valid && mid_ready_o;

  // Gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd256;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // Multiply, divide by 256 toward zero, saturate
  always_comb begin
    gain_s      = $signed({1'b0, gain_q});
    prod        = mid_i.signal * gain_s;
    prod_biased = prod + (prod[28] ? 29'sd255 : 29'sd0);
    quot        = prod_biased[28:8];
    if (quot > OutMax) begin
      out_sample_d = 16'sh7fff;
    end else if (quot < OutMin) begin
      out_sample_d = -16'sh8000;
    end else begin
      out_sample_d = quot[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_valid_q <= mid_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sample_q <= out_sample_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

endmodule

`default_nettype wire

// File: tb/tb_adpcm_4bit_decoder.sv
// ---------------------------------------------------------------------------
// tb_adpcm_4bit_decoder
// Self-checking bench for the 4-bit ADPCM decoder: a directed table that
// covers every code, saturation at both rails, save/restore and the unused
// action, then random nibble streams under several gains and idle patterns.
// Decoded samples are checked against a behavioral model or typed row values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adpcm_4bit_decoder;
  import adpcm4_pkg::*;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam int         ItemsPerPhase = 240;
  localparam int         NumPhases     = 6;
  localparam int         DrainPad      = 8;     // pipeline is three stages deep
  localparam int         HoldCycles    = 300;
  localparam int         QuietLimit    = 4000;
  localparam int         MaxPrinted    = 30;

  // Directed stimulus row; value is checked only when typed is set
  typedef struct packed {
    logic [1:0]         act;
    logic [3:0]         code;
    logic               typed;
    logic signed [15:0] value;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [1:0] action, [5:2] code_nibble, [7:6] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] sample
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Step sizes, floor(16 * 1.1^i)
  int unsigned step_tab [0:48] = '{
    16, 17, 19, 21, 23, 25, 28, 31, 34, 37,
    41, 45, 50, 55, 60, 66, 73, 80, 88, 97,
    107, 118, 130, 143, 157, 173, 190, 209, 230, 253,
    279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
    724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552
  };

  stim_row_t directed_rows [27] = '{
    '{ActRestore, 4'd0,  1'b0, 16'sd0},      // restore with nothing saved
    '{ActDecode,  4'd0,  1'b1, 16'sd2},
    '{ActDecode,  4'd8,  1'b1, 16'sd0},
    '{ActUnused,  4'd15, 1'b0, 16'sd0},      // unused action, ignored
    '{ActDecode,  4'd7,  1'b0, 16'sd0},
    '{ActDecode,  4'd7,  1'b0, 16'sd0},
    '{ActDecode,  4'd7,  1'b0, 16'sd0},
    '{ActDecode,  4'd7,  1'b0, 16'sd0},
    '{ActDecode,  4'd7,  1'b0, 16'sd0},
    '{ActDecode,  4'd7,  1'b1, 16'sd2047},   // positive rail, top step
    '{ActSave,    4'd0,  1'b0, 16'sd0},
    '{ActDecode,  4'd15, 1'b0, 16'sd0},
    '{ActDecode,  4'd15, 1'b1, -16'sd2048},  // negative rail
    '{ActSave,    4'd0,  1'b0, 16'sd0},      // second save has no effect
    '{ActRestore, 4'd0,  1'b0, 16'sd0},      // back to 2047, top step
    '{ActDecode,  4'd4,  1'b1, 16'sd2047},
    '{ActDecode,  4'd12, 1'b0, 16'sd0},
    '{ActDecode,  4'd1,  1'b0, 16'sd0},
    '{ActDecode,  4'd2,  1'b0, 16'sd0},
    '{ActDecode,  4'd3,  1'b0, 16'sd0},
    '{ActDecode,  4'd5,  1'b0, 16'sd0},
    '{ActDecode,  4'd6,  1'b0, 16'sd0},
    '{ActDecode,  4'd9,  1'b0, 16'sd0},
    '{ActDecode,  4'd10, 1'b0, 16'sd0},
    '{ActDecode,  4'd11, 1'b0, 16'sd0},
    '{ActDecode,  4'd13, 1'b0, 16'sd0},
    '{ActDecode,  4'd14, 1'b0, 16'sd0}
  };

  // Decoder model state
  int          dec_signal;
  int          dec_index;
  int          loop_signal;
  int          loop_index;
  bit          loop_saved;
  logic [15:0] gain_model;

  logic signed [15:0] expected_samples [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  quiet_cycles = 0;
  int  n_decode = 0;
  int  n_save = 0;
  int  n_restore = 0;
  int  n_unused = 0;
  int  n_gains = 0;

  adpcm_4bit_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the decoder model by one action; flags whether a sample results
  task automatic advance_decoder(input logic [1:0] act, input logic [3:0] code,
                                 output bit produces, output logic signed [15:0] predicted);
    int     st;
    int     diff;
    longint prod;
    longint mag;
    longint quot;
    produces  = 1'b0;
    predicted = '0;
    case (act)
      ActSave: begin
        if (!loop_saved) begin
          loop_signal = dec_signal;
          loop_index  = dec_index;
          loop_saved  = 1'b1;
        end
      end
      ActRestore: begin
        dec_signal = loop_signal;
        dec_index  = loop_index;
      end
      ActDecode: begin
        st   = step_tab[dec_index];
        diff = st / 8;
        if (code[2]) diff += st;
        if (code[1]) diff += st / 2;
        if (code[0]) diff += st / 4;
        if (code[3]) diff = -diff;
        dec_signal += diff;
        if (dec_signal > 2047) dec_signal = 2047;
        else if (dec_signal < -2048) dec_signal = -2048;
        // small codes step down by one, large ones up by 2, 4, 6, 8
        dec_index += (code[2:0] < 3'd4) ? -1 : 2 * (int'(code[2:0]) - 3);
        if (dec_index > 48) dec_index = 48;
        else if (dec_index < 0) dec_index = 0;
        // gain: Q8.8, truncate toward zero, saturate to 16 bits
        prod = longint'(dec_signal) * longint'(gain_model);
        mag  = (prod < 0) ? -prod : prod;
        quot = mag / 256;
        if (prod < 0) quot = -quot;
        if (quot > 32767) quot = 32767;
        if (quot < -32768) quot = -32768;
        predicted = 16'(quot);
        produces  = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t ns: %s: got %0d, want %0d", $realtime, what, $signed(got),
               $signed(want));
  endtask

  // Offer one item and wait for its transfer; valid stays high afterwards
  task automatic send_item(input logic [1:0] act, input logic [3:0] code,
                           input logic typed, input logic signed [15:0] typed_value);
    bit                 produces;
    logic signed [15:0] predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, code, act};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_decoder(act, code, produces, predicted);
    if (produces) expected_samples.push_back(typed ? typed_value : predicted);
    case (act)
      ActDecode:  n_decode++;
      ActSave:    n_save++;
      ActRestore: n_restore++;
      default:    n_unused++;
    endcase
  endtask

  // Gain is only written with the pipeline empty
  task automatic set_gain(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gain_model = value;
    n_gains++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output check against the oldest expected sample
  always @(posedge clk_i) begin : out_monitor
    logic signed [15:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with nothing pending", m_axis_tdata, 16'd0);
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (m_axis_tdata !== want) report_mismatch("sample mismatch", m_axis_tdata, want);
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("adpcm_4bit_decoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          counted;
    int          roll;
    logic [1:0]  act;
    logic [3:0]  code;
    logic [15:0] gain_val;
    bit          pressure;

    dec_signal  = 0;
    dec_index   = 0;
    loop_signal = 0;
    loop_index  = 0;
    loop_saved  = 1'b0;
    gain_model  = 16'd256;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at unity gain
    set_gain(16'd256);
    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].code, directed_rows[i].typed,
                directed_rows[i].value);

    // Random phases: gain setting and idle pattern change per phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      pressure = 1'b0;
      case (ph)
        0: begin gain_val = 16'd0;     send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin gain_val = 16'hFFFF;  send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin
          gain_val = 16'($urandom_range(65535));
          send_idle_pct = 0; recv_stall_pct = 62;
        end
        3: begin gain_val = 16'd255;   send_idle_pct = 28; recv_stall_pct = 28; end
        4: begin
          gain_val = 16'd256; send_idle_pct = 0; recv_stall_pct = 0; pressure = 1'b1;
        end
        default: begin
          gain_val = 16'($urandom_range(65535));
          send_idle_pct = 28; recv_stall_pct = 28;
        end
      endcase
      set_gain(gain_val);
      if (pressure) hold_request = 1'b1;
      counted = 0;
      while (counted < ItemsPerPhase) begin
        roll = $urandom_range(99);
        if (roll < 82)      act = ActDecode;
        else if (roll < 90) act = ActSave;
        else if (roll < 96) act = ActRestore;
        else                act = ActUnused;
        // bias toward full-magnitude codes to keep hitting the rails
        if ($urandom_range(99) < 15) code = {1'($urandom_range(1)), 3'b111};
        else                         code = 4'($urandom_range(15));
        send_item(act, code, 1'b0, 16'sd0);
        counted++;
      end
    end

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (2 * DrainPad) @(posedge clk_i);

    $display("covered %0d decodes, %0d saves, %0d restores, %0d unused actions",
             n_decode, n_save, n_restore, n_unused);
    $display("checked %0d samples over %0d gain settings, %0d mismatches",
             results_checked, n_gains, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("adpcm_4bit_decoder test passed");
    end else begin
      $display("adpcm_4bit_decoder test failed");
    end
    $finish;
  end

endmodule
